// ===== rtl/bbc_pkg.sv =====
// Shared constants for the bracket balance checker: status codes,
// character codes, register indexes and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned LINE_WIDTH  = 16;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned LINE_W  = 16;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned MASK_W  = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_RUN      = 3'd0,
    ST_OK       = 3'd1,
    ST_NO_OPEN  = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_NO_CLOSE = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPEN_MASK  = 2'd0,
    CFG_CLOSE_MASK = 2'd1,
    CFG_QUOTE_MODE = 2'd2
  } cfg_idx_e;

  localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LSQUARE = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RSQUARE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LCURLY  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RCURLY  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

endpackage

`default_nettype wire

// ===== rtl/bracket_balance_checker_core.sv =====
// Bracket balance checker top level: kind stack in a synchronous memory,
// top of stack in a register. Depends on bbc_pkg.
// Result valid in the cycle after accept. Throughput: one request per cycle
// unless the output stalls, set by the stack read port (entry below the top
// is prefetched every cycle, so pops and pushes can follow back to back).
// Reset (async, active low) clears pointer, parity, error and output valid,
// sets line count to 1 and config to defaults; stack memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bracket_balance_checker_core #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH,
  parameter int unsigned LINE_WIDTH  = bbc_pkg::LINE_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bbc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bbc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [bbc_pkg::CHAR_W-1:0]      char_code_i,
  input  wire logic                            end_of_text_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [bbc_pkg::STAT_W-1:0]           status_o,
  output logic [bbc_pkg::LINE_W-1:0]           line_number_o,
  output logic [bbc_pkg::DEPTH_W-1:0]          nesting_depth_o
);

  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned KW  = bbc_pkg::KIND_W;

  // configuration
  logic [bbc_pkg::MASK_W-1:0] open_mask_q, close_mask_q;
  logic                       quote_mode_q;

  // control state
  logic [SPW-1:0]        sp_q, sp_d;
  logic                  parity_q, parity_d;
  logic [LINE_WIDTH-1:0] line_q, line_d;
  bbc_pkg::status_e      err_q, err_d;
  logic [KW-1:0]         tos_q, tos_d;

  // stack memory
  logic [KW-1:0] stack_mem [STACK_DEPTH];
  logic [KW-1:0] below_q;
  logic          push_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [SPW-1:0] sp_m2;

  // output register
  logic                        out_valid_q;
  logic [bbc_pkg::STAT_W-1:0]  out_status_q, out_status_d;
  logic [bbc_pkg::LINE_W-1:0]  out_line_q, out_line_d;
  logic [bbc_pkg::DEPTH_W-1:0] out_depth_q, out_depth_d;

  logic          accept;
  logic          is_open, is_close, skip;
  logic [KW-1:0] open_k, close_k;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    is_open  = 1'b0;
    is_close = 1'b0;
    open_k   = bbc_pkg::KIND_ROUND;
    close_k  = bbc_pkg::KIND_ROUND;
    case (char_code_i)
      bbc_pkg::CH_LPAREN: begin
        is_open = open_mask_q[0];
        open_k  = bbc_pkg::KIND_ROUND;
      end
      bbc_pkg::CH_LSQUARE: begin
        is_open = open_mask_q[1];
        open_k  = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_LCURLY: begin
        is_open = open_mask_q[2];
        open_k  = bbc_pkg::KIND_CURLY;
      end
      bbc_pkg::CH_RPAREN: begin
        is_close = close_mask_q[0];
        close_k  = bbc_pkg::KIND_ROUND;
      end
      bbc_pkg::CH_RSQUARE: begin
        is_close = close_mask_q[1];
        close_k  = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_RCURLY: begin
        is_close = close_mask_q[2];
        close_k  = bbc_pkg::KIND_CURLY;
      end
      default: begin
        is_open  = 1'b0;
        is_close = 1'b0;
      end
    endcase
  end

  always_comb begin
    sp_d         = sp_q;
    parity_d     = parity_q;
    line_d       = line_q;
    err_d        = err_q;
    tos_d        = tos_q;
    push_we      = 1'b0;
    skip         = 1'b0;
    out_status_d = out_status_q;
    out_line_d   = out_line_q;
    out_depth_d  = out_depth_q;

    if (accept) begin
      if (end_of_text_i) begin
        if (err_q != bbc_pkg::ST_RUN) begin
          out_status_d = err_q;
        end else if (sp_q == '0) begin
          out_status_d = bbc_pkg::ST_OK;
        end else begin
          out_status_d = bbc_pkg::ST_NO_CLOSE;
        end
        out_line_d  = bbc_pkg::LINE_W'(line_q);
        out_depth_d = bbc_pkg::DEPTH_W'(sp_q);
        sp_d     = '0;
        parity_d = 1'b0;
        line_d   = LINE_WIDTH'(1);
        err_d    = bbc_pkg::ST_RUN;
      end else begin
        if (err_q == bbc_pkg::ST_RUN) begin
          if (char_code_i == bbc_pkg::CH_QUOTE) begin
            parity_d = ~parity_q;
          end
          if (char_code_i == bbc_pkg::CH_NEWLINE && line_q != '1) begin
            line_d = line_q + LINE_WIDTH'(1);
          end
          skip = quote_mode_q & parity_d;
          if (!skip) begin
            if (is_open) begin
              if (sp_q >= SPW'(STACK_DEPTH)) begin
                err_d = bbc_pkg::ST_OVERFLOW;
              end else begin
                push_we = 1'b1;
                tos_d   = open_k;
                sp_d    = sp_q + SPW'(1);
              end
            end else if (is_close) begin
              if (sp_q == '0) begin
                err_d = bbc_pkg::ST_NO_OPEN;
              end else if (tos_q == close_k) begin
                tos_d = below_q;
                sp_d  = sp_q - SPW'(1);
              end else begin
                err_d = bbc_pkg::ST_MISMATCH;
              end
            end
          end
        end
        out_status_d = err_d;
        out_line_d   = bbc_pkg::LINE_W'(line_d);
        out_depth_d  = bbc_pkg::DEPTH_W'(sp_d);
      end
    end
  end

  // write at the old pointer on push; prefetch the entry below the new top
  assign sp_m2   = sp_d - SPW'(2);
  assign wr_addr = sp_q[AW-1:0];
  assign rd_addr = sp_m2[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (push_we) begin
      stack_mem[wr_addr] <= open_k;
    end
    below_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_mask_q  <= '1;
      close_mask_q <= '1;
      quote_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bbc_pkg::CFG_OPEN_MASK:  open_mask_q  <= cfg_wdata_i;
        bbc_pkg::CFG_CLOSE_MASK: close_mask_q <= cfg_wdata_i;
        bbc_pkg::CFG_QUOTE_MODE: quote_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      parity_q    <= 1'b0;
      line_q      <= LINE_WIDTH'(1);
      err_q       <= bbc_pkg::ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      sp_q     <= sp_d;
      parity_q <= parity_d;
      line_q   <= line_d;
      err_q    <= err_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q        <= tos_d;
    out_status_q <= out_status_d;
    out_line_q   <= out_line_d;
    out_depth_q  <= out_depth_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign line_number_o   = out_line_q;
  assign nesting_depth_o = out_depth_q;

endmodule

`default_nettype wire

// ===== rtl/bbc_checker.sv =====
// Port-level assertions for the bracket balance checker, bound to the top
// level. Depends on bbc_pkg and bracket_balance_checker_core.
`timescale 1ns / 1ps
`default_nettype none

module bbc_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [bbc_pkg::STAT_W-1:0]      status_o,
  input wire logic [bbc_pkg::LINE_W-1:0]      line_number_o,
  input wire logic [bbc_pkg::DEPTH_W-1:0]     nesting_depth_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(status_o) && $stable(line_number_o) && $stable(nesting_depth_o))
    else $error("stalled result changed");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request gave no result");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");

  a_ok_means_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bbc_pkg::ST_OK |-> nesting_depth_o == '0)
    else $error("ok verdict with open brackets");

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .line_number_o   (line_number_o),
  .nesting_depth_o (nesting_depth_o)
);

`default_nettype wire

// ===== tb/tb_bracket_balance_checker_core.sv =====
// Self-checking testbench for bracket_balance_checker_core: streams text
// requests with random idling and stalls and scores every result against
// its own nesting predictor. Depends on bbc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_bracket_balance_checker_core;

  localparam logic [bbc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [bbc_pkg::LINE_W-1:0]    LINE_MAX  = '1;

  typedef struct packed {
    bbc_pkg::status_e              status;
    logic [bbc_pkg::LINE_W-1:0]    line;
    logic [bbc_pkg::DEPTH_W-1:0]   depth;
  } verdict_t;

  typedef enum int {
    FLAW_NONE, FLAW_UNCLOSED, FLAW_EXTRA_CLOSE, FLAW_WRONG_KIND, FLAW_NOISE
  } flaw_e;

  class nesting_ledger;
    logic [bbc_pkg::KIND_W-1:0] kinds [bbc_pkg::STACK_DEPTH];
    int unsigned                depth;
    bit                         parity;
    logic [bbc_pkg::LINE_W-1:0] line;
    bbc_pkg::status_e           err;
    logic [bbc_pkg::MASK_W-1:0] open_mask;
    logic [bbc_pkg::MASK_W-1:0] close_mask;
    bit                         quote_mode;
    verdict_t                   verdict_q[$];
    int unsigned                mismatches;

    function new();
      open_mask  = '1;
      close_mask = '1;
      quote_mode = 1'b0;
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_text();
      depth  = 0;
      parity = 1'b0;
      line   = bbc_pkg::LINE_W'(1);
      err    = bbc_pkg::ST_RUN;
    endfunction

    function void set_reg(logic [bbc_pkg::CFG_IDX_W-1:0] idx,
                          logic [bbc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        bbc_pkg::CFG_OPEN_MASK:  open_mask  = data[bbc_pkg::MASK_W-1:0];
        bbc_pkg::CFG_CLOSE_MASK: close_mask = data[bbc_pkg::MASK_W-1:0];
        bbc_pkg::CFG_QUOTE_MODE: quote_mode = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [bbc_pkg::CHAR_W-1:0] c, logic eot);
      verdict_t                   v;
      logic                       is_open;
      logic                       is_close;
      logic [bbc_pkg::KIND_W-1:0] k;
      if (eot) begin
        v.status = (err != bbc_pkg::ST_RUN) ? err :
                   ((depth == 0) ? bbc_pkg::ST_OK : bbc_pkg::ST_NO_CLOSE);
        v.line   = line;
        v.depth  = bbc_pkg::DEPTH_W'(depth);
        verdict_q.push_back(v);
        clear_text();
        return;
      end
      if (err == bbc_pkg::ST_RUN) begin
        if (c == bbc_pkg::CH_QUOTE) parity = ~parity;
        if (c == bbc_pkg::CH_NEWLINE && line != LINE_MAX) line++;
        if (!(quote_mode && parity)) begin
          is_open  = 1'b0;
          is_close = 1'b0;
          k        = bbc_pkg::KIND_ROUND;
          case (c)
            bbc_pkg::CH_LPAREN:  begin is_open  = 1'b1; k = bbc_pkg::KIND_ROUND;  end
            bbc_pkg::CH_LSQUARE: begin is_open  = 1'b1; k = bbc_pkg::KIND_SQUARE; end
            bbc_pkg::CH_LCURLY:  begin is_open  = 1'b1; k = bbc_pkg::KIND_CURLY;  end
            bbc_pkg::CH_RPAREN:  begin is_close = 1'b1; k = bbc_pkg::KIND_ROUND;  end
            bbc_pkg::CH_RSQUARE: begin is_close = 1'b1; k = bbc_pkg::KIND_SQUARE; end
            bbc_pkg::CH_RCURLY:  begin is_close = 1'b1; k = bbc_pkg::KIND_CURLY;  end
            default: ;
          endcase
          if (is_open && open_mask[k]) begin
            if (depth >= bbc_pkg::STACK_DEPTH) begin
              err = bbc_pkg::ST_OVERFLOW;
            end else begin
              kinds[depth] = k;
              depth++;
            end
          end else if (is_close && close_mask[k]) begin
            if (depth == 0) err = bbc_pkg::ST_NO_OPEN;
            else if (kinds[depth-1] == k) depth--;
            else err = bbc_pkg::ST_MISMATCH;
          end
        end
      end
      v.status = err;
      v.line   = line;
      v.depth  = bbc_pkg::DEPTH_W'(depth);
      verdict_q.push_back(v);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [bbc_pkg::STAT_W-1:0] st, logic [bbc_pkg::LINE_W-1:0] ln,
                      logic [bbc_pkg::DEPTH_W-1:0] dp);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected result status %0d line %0d depth %0d", st, ln, dp));
        return;
      end
      v = verdict_q.pop_front();
      if (st !== v.status)
        report($sformatf("status got %0d want %0d", st, v.status));
      if (ln !== v.line)
        report($sformatf("line_number got %0d want %0d", ln, v.line));
      if (dp !== v.depth)
        report($sformatf("nesting_depth got %0d want %0d", dp, v.depth));
    endtask
  endclass

  logic                           clk_i       = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           cfg_we      = 1'b0;
  logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [bbc_pkg::CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                           in_valid    = 1'b0;
  logic [bbc_pkg::CHAR_W-1:0]     char_code   = '0;
  logic                           end_of_text = 1'b0;
  logic                           out_stall   = 1'b0;
  logic                           in_stall;
  logic                           out_valid;
  logic [bbc_pkg::STAT_W-1:0]     status;
  logic [bbc_pkg::LINE_W-1:0]     line_number;
  logic [bbc_pkg::DEPTH_W-1:0]    nesting_depth;
  bit                             quiet = 1'b0;
  nesting_ledger                  ledger;

  bracket_balance_checker_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .char_code_i     (char_code),
    .end_of_text_i   (end_of_text),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .line_number_o   (line_number),
    .nesting_depth_o (nesting_depth)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit take_break();
    return !quiet && ($urandom_range(99) < 19);
  endfunction

  always @(negedge clk_i) out_stall <= take_break();

  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall)
      ledger.check_result(status, line_number, nesting_depth);
  end

  function automatic logic [bbc_pkg::CHAR_W-1:0] open_char(logic [bbc_pkg::KIND_W-1:0] k);
    case (k)
      bbc_pkg::KIND_ROUND:  return bbc_pkg::CH_LPAREN;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_LSQUARE;
      default:              return bbc_pkg::CH_LCURLY;
    endcase
  endfunction

  function automatic logic [bbc_pkg::CHAR_W-1:0] close_char(logic [bbc_pkg::KIND_W-1:0] k);
    case (k)
      bbc_pkg::KIND_ROUND:  return bbc_pkg::CH_RPAREN;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_RSQUARE;
      default:              return bbc_pkg::CH_RCURLY;
    endcase
  endfunction

  function automatic logic [bbc_pkg::KIND_W-1:0] any_kind();
    return bbc_pkg::KIND_W'($urandom_range(2));
  endfunction

  // plain text byte: brackets folded to newline, some extra newlines and quotes
  function automatic logic [bbc_pkg::CHAR_W-1:0] filler();
    logic [bbc_pkg::CHAR_W-1:0] c;
    c = bbc_pkg::CHAR_W'($urandom_range(255));
    if (c inside {bbc_pkg::CH_LPAREN, bbc_pkg::CH_RPAREN, bbc_pkg::CH_LSQUARE,
                  bbc_pkg::CH_RSQUARE, bbc_pkg::CH_LCURLY, bbc_pkg::CH_RCURLY})
      c = bbc_pkg::CH_NEWLINE;
    else if ($urandom_range(7) == 0)
      c = bbc_pkg::CH_NEWLINE;
    else if ($urandom_range(15) == 0)
      c = bbc_pkg::CH_QUOTE;
    return c;
  endfunction

  task automatic send_byte(input logic [bbc_pkg::CHAR_W-1:0] c, input logic eot);
    @(negedge clk_i);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    char_code   <= c;
    end_of_text <= eot;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    ledger.note_request(c, eot);
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    send_byte(bbc_pkg::CHAR_W'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input int unsigned len, input int unsigned max_open,
                           input flaw_e flaw);
    logic [bbc_pkg::KIND_W-1:0] open_kinds[$];
    logic [bbc_pkg::KIND_W-1:0] k;
    for (int unsigned i = 0; i < len; i++) begin
      if (flaw == FLAW_NOISE) begin
        send_byte(bbc_pkg::CHAR_W'($urandom_range(255)), 1'b0);
      end else begin
        case ($urandom_range(4))
          0: begin
            if (open_kinds.size() < max_open) begin
              k = any_kind();
              open_kinds.push_back(k);
              send_byte(open_char(k), 1'b0);
            end else begin
              send_byte(filler(), 1'b0);
            end
          end
          1: begin
            if (open_kinds.size() != 0) send_byte(close_char(open_kinds.pop_back()), 1'b0);
            else send_byte(filler(), 1'b0);
          end
          2: begin
            // quoted stray bracket, only harmless in quote mode
            if (ledger.quote_mode) begin
              send_byte(bbc_pkg::CH_QUOTE, 1'b0);
              k = any_kind();
              send_byte($urandom_range(1) ? open_char(k) : close_char(k), 1'b0);
              send_byte(bbc_pkg::CH_QUOTE, 1'b0);
            end else begin
              send_byte(filler(), 1'b0);
            end
          end
          default: send_byte(filler(), 1'b0);
        endcase
      end
    end
    case (flaw)
      FLAW_NONE: begin
        while (open_kinds.size() != 0) send_byte(close_char(open_kinds.pop_back()), 1'b0);
      end
      FLAW_UNCLOSED: begin
        if (open_kinds.size() == 0) send_byte(open_char(any_kind()), 1'b0);
      end
      FLAW_EXTRA_CLOSE: begin
        while (open_kinds.size() != 0) send_byte(close_char(open_kinds.pop_back()), 1'b0);
        send_byte(close_char(any_kind()), 1'b0);
      end
      FLAW_WRONG_KIND: begin
        if (open_kinds.size() == 0) begin
          k = any_kind();
          open_kinds.push_back(k);
          send_byte(open_char(k), 1'b0);
        end
        k = open_kinds[$];
        send_byte(close_char((k == bbc_pkg::KIND_CURLY) ? bbc_pkg::KIND_ROUND :
                             bbc_pkg::KIND_W'(k + 1'b1)), 1'b0);
      end
      default: ;
    endcase
    send_byte(bbc_pkg::CHAR_W'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_deep(input int unsigned n);
    logic [bbc_pkg::KIND_W-1:0] open_kinds[$];
    logic [bbc_pkg::KIND_W-1:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      k = any_kind();
      open_kinds.push_back(k);
      send_byte(open_char(k), 1'b0);
      if ($urandom_range(9) == 0) send_byte(filler(), 1'b0);
    end
    while (open_kinds.size() != 0) send_byte(close_char(open_kinds.pop_back()), 1'b0);
    send_byte(bbc_pkg::CHAR_W'($urandom_range(255)), 1'b1);
  endtask

  task automatic random_texts(input int unsigned count);
    int unsigned r;
    flaw_e       flaw;
    for (int unsigned t = 0; t < count; t++) begin
      r = $urandom_range(9);
      if (r < 6)       flaw = FLAW_NONE;
      else if (r == 6) flaw = FLAW_UNCLOSED;
      else if (r == 7) flaw = FLAW_EXTRA_CLOSE;
      else if (r == 8) flaw = FLAW_WRONG_KIND;
      else             flaw = FLAW_NOISE;
      send_text($urandom_range(24), $urandom_range(1, 8), flaw);
    end
  endtask

  task automatic rest_until_drained();
    @(negedge clk_i) in_valid <= 1'b0;
    while (ledger.verdict_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic poke_reg(input logic [bbc_pkg::CFG_IDX_W-1:0] idx,
                          input logic [bbc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    ledger.set_reg(idx, data);
  endtask

  task automatic configure(input logic [bbc_pkg::MASK_W-1:0] open_m,
                           input logic [bbc_pkg::MASK_W-1:0] close_m,
                           input logic qmode);
    rest_until_drained();
    poke_reg(bbc_pkg::CFG_OPEN_MASK, open_m);
    poke_reg(bbc_pkg::CFG_CLOSE_MASK, close_m);
    poke_reg(bbc_pkg::CFG_QUOTE_MODE, {2'($urandom_range(3)), qmode});
    poke_reg(CFG_SPARE, bbc_pkg::CFG_DATA_W'($urandom_range(7)));
    @(negedge clk_i) cfg_we <= 1'b0;
  endtask

  initial begin
    ledger = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_n <= 1'b1;

    send_line("([{\n}])");
    send_line(")x\n");
    send_line("(]");
    send_byte(bbc_pkg::CH_LSQUARE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_deep(bbc_pkg::STACK_DEPTH + 1);
    send_deep(bbc_pkg::STACK_DEPTH);
    random_texts(2);

    configure(3'b111, 3'b111, 1'b1);
    send_line("\"(\"(\")\")");
    random_texts(2);

    configure(3'b000, 3'b000, 1'b0);
    random_texts(2);
    configure(3'b111, 3'b000, 1'b1);
    random_texts(2);
    configure(3'b000, 3'b111, 1'b0);
    random_texts(2);

    quiet = 1'b1;
    configure(bbc_pkg::MASK_W'($urandom_range(7)), bbc_pkg::MASK_W'($urandom_range(7)),
              1'($urandom_range(1)));
    random_texts(4);
    quiet = 1'b0;
    configure(bbc_pkg::MASK_W'($urandom_range(7)), bbc_pkg::MASK_W'($urandom_range(7)),
              1'($urandom_range(1)));
    random_texts(2);

    // error reported at a later line
    configure(3'b111, 3'b111, 1'b0);
    for (int i = 0; i < 20; i++) send_byte(bbc_pkg::CH_NEWLINE, 1'b0);
    send_line("())");

    rest_until_drained();
    if (ledger.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
